// ----- sv/lag_pkg.sv -----
// Shared types and constants for the life automaton generation core.
package lag_pkg;

   localparam int GRID_COLS = 256;
   localparam int GRID_ROWS = 128;
   localparam int COL_W     = $clog2(GRID_COLS);
   localparam int ROW_W     = $clog2(GRID_ROWS);
   localparam int BORN_COUNT = 3;
   localparam int KEEP_COUNT = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  col;
      logic [6:0]  row;
      logic        value;
   } req_type;

   typedef struct packed {
      logic cell_alive;
      logic done_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL_FIN,
      ST_GEN_TOP,
      ST_GEN_MID,
      ST_GEN_ROW,
      ST_DONE
   } state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic             accept;
      logic             rd_en;
      logic [ROW_W-1:0] rd_row;
      logic             load_above;
      logic             load_mid;
      logic             gen_write;
      logic [ROW_W-1:0] gen_row;
      logic             cell_fin;
      logic             swap;
      logic             rsp_load;
   } cmd_type;

endpackage

// ----- sv/lag_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lag_ctrl.sv -----
// Sequencer: handshakes, cell access steps and the row sweep of a generation.
module lag_ctrl
   import lag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
   localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W+1)'(GRID_ROWS);

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W:0]   ahead_sum;
   logic [ROW_W-1:0] ahead_row;

   // Row two ahead of the one being written, wrapped
   always_comb begin
      ahead_sum = {1'b0, row_ff} + (ROW_W+1)'(2);
      if (ahead_sum >= ROWS_EXT) begin
         ahead_sum = ahead_sum - ROWS_EXT;
      end
      ahead_row = ahead_sum[ROW_W-1:0];
   end

   // Hold state, row counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_data.opcode)
                  OP_WRITE, OP_READ: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_row = req_data.row;
                     state_in   = ST_CELL_FIN;
                  end
                  OP_STEP: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_row = LAST_ROW;
                     state_in   = ST_GEN_TOP;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CELL_FIN: begin
            cmd.cell_fin = 1'b1;
            state_in     = ST_DONE;
         end
         ST_GEN_TOP: begin
            cmd.load_above = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_row     = '0;
            state_in       = ST_GEN_MID;
         end
         ST_GEN_MID: begin
            cmd.load_mid = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_row   = ROW_W'(1);
            row_in       = '0;
            state_in     = ST_GEN_ROW;
         end
         ST_GEN_ROW: begin
            cmd.gen_write  = 1'b1;
            cmd.gen_row    = row_ff;
            cmd.load_above = 1'b1;
            cmd.load_mid   = 1'b1;
            if (row_ff == LAST_ROW) begin
               cmd.swap = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_row = ahead_row;
               row_in     = row_ff + ROW_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/lag_dpath.sv -----
// Datapath: two row-wide grid buffers, row window, next-row logic, result.
module lag_dpath
   import lag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output rsp_type rsp_data
);

   logic                 sel_ff;
   logic [GRID_ROWS-1:0] valid_a_ff, valid_b_ff;
   logic                 rd_valid_ff;
   req_type              req_ff;
   logic [GRID_COLS-1:0] above_ff, mid_ff;
   logic                 alive_ff;
   rsp_type              rsp_ff;

   logic [GRID_COLS-1:0] rd_a, rd_b, row_in, next_row, cell_row;
   logic                 in_grid;
   logic                 wr_a, wr_b;
   logic [ROW_W-1:0]     wr_row;
   logic [GRID_COLS-1:0] wr_data;
   logic [3:0]           count;

   // Source row as read, dead where the row was never written
   assign row_in = rd_valid_ff ? (sel_ff ? rd_b : rd_a) : '0;

   assign in_grid = ({1'b0, req_ff.col} < (COL_W+1)'(GRID_COLS)) &&
                    ({1'b0, req_ff.row} < (ROW_W+1)'(GRID_ROWS));

   // Next generation of the middle row from its two wrapped neighbors
   always_comb begin
      next_row = '0;
      count    = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         count = 4'(above_ff[(c + GRID_COLS - 1) % GRID_COLS]) +
                 4'(above_ff[c]) +
                 4'(above_ff[(c + 1) % GRID_COLS]) +
                 4'(mid_ff[(c + GRID_COLS - 1) % GRID_COLS]) +
                 4'(mid_ff[(c + 1) % GRID_COLS]) +
                 4'(row_in[(c + GRID_COLS - 1) % GRID_COLS]) +
                 4'(row_in[c]) +
                 4'(row_in[(c + 1) % GRID_COLS]);
         next_row[c] = (count == 4'(BORN_COUNT)) ||
                       (mid_ff[c] && (count == 4'(KEEP_COUNT)));
      end
   end

   // Current row with the addressed cell replaced
   always_comb begin
      cell_row = row_in;
      cell_row[req_ff.col] = req_ff.value;
   end

   // Steer writes: generation to the other buffer, cell write to current
   always_comb begin
      wr_a    = 1'b0;
      wr_b    = 1'b0;
      wr_row  = req_ff.row;
      wr_data = cell_row;
      if (cmd.gen_write) begin
         wr_row  = cmd.gen_row;
         wr_data = next_row;
         wr_a    = sel_ff;
         wr_b    = ~sel_ff;
      end else if (cmd.cell_fin && in_grid && req_ff.opcode == OP_WRITE) begin
         wr_a = ~sel_ff;
         wr_b = sel_ff;
      end
   end

   lag_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_grid_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_row),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_row),
      .rd_data (rd_a)
   );

   lag_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_grid_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_row),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_row),
      .rd_data (rd_b)
   );

   // Buffer select and row valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff     <= 1'b0;
         valid_a_ff <= '0;
         valid_b_ff <= '0;
      end else begin
         if (wr_a) begin
            valid_a_ff[wr_row] <= 1'b1;
         end
         if (wr_b) begin
            valid_b_ff[wr_row] <= 1'b1;
         end
         if (cmd.swap) begin
            sel_ff <= ~sel_ff;
         end
      end
   end

   // Capture request, row window, read bit and result
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= sel_ff ? valid_b_ff[cmd.rd_row] : valid_a_ff[cmd.rd_row];
      end
      if (cmd.accept) begin
         req_ff   <= req_data;
         alive_ff <= 1'b0;
      end
      if (cmd.cell_fin && in_grid && req_ff.opcode == OP_READ) begin
         alive_ff <= row_in[req_ff.col];
      end
      if (cmd.load_above) begin
         above_ff <= cmd.load_mid ? mid_ff : row_in;
      end
      if (cmd.load_mid) begin
         mid_ff <= row_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff.cell_alive <= alive_ff;
         rsp_ff.done_res   <= 1'b1;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- sv/life_automaton_generation_core.sv -----
// Top level of the toroidal life grid: cell access and generation step.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_data (opcode, col, row, value)
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_data (cell_alive, done_res)
//
// A cell write or read passes through the finish and done states before its result
// is registered; a generation reads one row per cycle from the grid RAM.
// Each buffer is one row wide, so all cells of a row are updated at once.
// Reset clears row valid bits at once; no clearing pass is needed.
// A stalled result holds the block in its final state until it is taken.
module life_automaton_generation_core
   import lag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;

   lag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lag_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule
